// File: hw/rtl/xor_float_delta_encoder_macros.svh
// Assertion macros shared by the XOR float delta encoder RTL.
`ifndef XOR_FLOAT_DELTA_ENCODER_MACROS_SVH
`define XOR_FLOAT_DELTA_ENCODER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define XFDE_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |-> (cons)) \
        else $error("xfde assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define XFDE_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |=> (cons)) \
        else $error("xfde assertion failed");
`else
`define XFDE_ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons)
`define XFDE_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons)
`endif

`endif

// File: hw/rtl/xfde_pkg.sv
// Types and constants of the XOR float delta encoder.
`default_nettype none

package xfde_pkg;

    localparam int SAMPLE_W    = 64;
    localparam int COUNT_W     = 7;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 88;

    // control codes
    localparam logic [1:0] CODE_SAME   = 2'd0;
    localparam logic [1:0] CODE_WINDOW = 2'd1;
    localparam logic [1:0] CODE_NEW    = 2'd3;

    // control bit counts
    localparam logic [1:0] CLEN_RAW  = 2'd0;
    localparam logic [1:0] CLEN_ZERO = 2'd1;
    localparam logic [1:0] CLEN_XOR  = 2'd2;

    localparam logic [4:0] LEAD_MAX  = 5'd31;
    localparam logic [6:0] FULL_LEN  = 7'd64;

    // one result record; first member sits in the top bits
    typedef struct packed {
        logic [6:0]  payload_len;
        logic [63:0] payload;
        logic [5:0]  width_field;
        logic [4:0]  lead_field;
        logic        has_header;
        logic [1:0]  ctrl_len;
        logic [1:0]  ctrl_code;
    } xfde_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/xfde_lzc.sv
// Leading zero counter over a 64-bit word, byte lanes then priority pick.
`default_nettype none

module xfde_lzc (
    input  wire logic [63:0] value,
    output logic [6:0]       count
);
    import xfde_pkg::*;

    function automatic logic [2:0] byte_lzc(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd7;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                n = 3'(7 - i);
            end
        end
        return n;
    endfunction

    logic [7:0] lane_nz;
    logic [2:0] lane_lz [8];

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            lane_nz[k] = |value[k*8 +: 8];
            lane_lz[k] = byte_lzc(value[k*8 +: 8]);
        end
    end

    // highest non-zero byte wins
    always_comb
    begin
        count = FULL_LEN;
        for (int k = 0; k < 8; k++)
        begin
            if (lane_nz[k])
            begin
                count = {1'b0, 3'(7 - k), lane_lz[k]};
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/xfde_core.sv
// Encoder datapath and history state (previous sample, stored window pair).
`default_nettype none

`include "xor_float_delta_encoder_macros.svh"

module xfde_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  commit,
    input  wire logic [63:0]           sample,
    output xfde_pkg::xfde_result_t     result
);
    import xfde_pkg::*;

    logic        started_reg, started_next;
    logic [63:0] prev_bits_reg, prev_bits_next;
    logic [4:0]  prev_lead_reg, prev_lead_next;
    logic [6:0]  prev_width_reg, prev_width_next;

    logic [63:0] xor_val;
    logic [63:0] xor_rev;
    logic [6:0]  lead_raw;
    logic [6:0]  trail_raw;
    logic [4:0]  lead_sat;
    logic [6:0]  width;
    logic [63:0] window;
    logic        pair_match;

    assign xor_val = sample ^ prev_bits_reg;

    always_comb
    begin
        for (int i = 0; i < SAMPLE_W; i++)
        begin
            xor_rev[i] = xor_val[SAMPLE_W - 1 - i];
        end
    end

    xfde_lzc u_lead (
        .value (xor_val),
        .count (lead_raw)
    );

    xfde_lzc u_trail (
        .value (xor_rev),
        .count (trail_raw)
    );

    // saturate at 31; window grows on the left to keep the sum at 64
    assign lead_sat   = (lead_raw[6:5] != 2'd0) ? LEAD_MAX : lead_raw[4:0];
    assign width      = FULL_LEN - {2'b00, lead_sat} - trail_raw;
    assign window     = xor_val >> trail_raw[5:0];
    assign pair_match = (lead_sat == prev_lead_reg) && (width == prev_width_reg);

    always_comb
    begin
        result          = '0;
        started_next    = started_reg;
        prev_bits_next  = prev_bits_reg;
        prev_lead_next  = prev_lead_reg;
        prev_width_next = prev_width_reg;
        if (!started_reg)
        begin
            result.ctrl_code   = CODE_SAME;
            result.ctrl_len    = CLEN_RAW;
            result.payload     = sample;
            result.payload_len = FULL_LEN;
            started_next       = 1'b1;
        end
        else if (xor_val == '0)
        begin
            result.ctrl_code = CODE_SAME;
            result.ctrl_len  = CLEN_ZERO;
        end
        else
        begin
            result.ctrl_len    = CLEN_XOR;
            result.payload     = window;
            result.payload_len = width;
            if (pair_match)
            begin
                result.ctrl_code = CODE_WINDOW;
            end
            else
            begin
                result.ctrl_code   = CODE_NEW;
                result.has_header  = 1'b1;
                result.lead_field  = lead_sat;
                result.width_field = width[5:0];
                prev_lead_next     = lead_sat;
                prev_width_next    = width;
            end
        end
        prev_bits_next = sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg    <= 1'b0;
            prev_bits_reg  <= '0;
            prev_lead_reg  <= '0;
            prev_width_reg <= FULL_LEN;
        end
        else if (commit)
        begin
            started_reg    <= started_next;
            prev_bits_reg  <= prev_bits_next;
            prev_lead_reg  <= prev_lead_next;
            prev_width_reg <= prev_width_next;
        end
    end

    `XFDE_ASSERT_NEXT(a_first_sets_started, clk, rst_n, commit && !started_reg, started_reg)
    `XFDE_ASSERT_IMPL(a_header_only_new, clk, rst_n, result.has_header, result.ctrl_code == CODE_NEW)
    `XFDE_ASSERT_NEXT(a_pair_stored, clk, rst_n, commit && result.ctrl_code == CODE_NEW, prev_width_reg == $past(result.payload_len))

endmodule

`default_nettype wire

// File: hw/rtl/xor_float_delta_encoder.sv
// Top level of the XOR float delta encoder: stream ports, input and result registers.
//
// Usage:
//   s_axis carries one 64-bit double bit pattern per transfer (sample_bits).
//   m_axis carries one encoded record per sample: control code and length,
//   optional header (leading count, width), right-aligned window and its length.
//   The first sample after reset goes out raw with payload_len 64.
// A sample taken from s_axis sits in the input register, is encoded in the
//   core and is loaded into the result register that drives m_axis, when
//   that register is free or draining.
// Throughput: one sample per cycle while the receiver keeps up; the zero
//   counters and window shifter sit between the input register and the result
//   register, and the history state updates at the same edge the result is loaded.
// Stall: when m_axis_tready is low and a result is waiting, the result
//   register holds, the input register holds its sample and s_axis_tready
//   drops once it is full; nothing is dropped or repeated.
// Reset: asynchronous, active low; empties both registers and returns the
//   history to its start state (next sample is sent raw).
`default_nettype none

`include "xor_float_delta_encoder_macros.svh"

module xor_float_delta_encoder (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [63:0] sample_bits
    input  wire logic [xfde_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [1:0] ctrl_code, [3:2] ctrl_len, [4] has_header, [9:5] lead_field,
    // [15:10] width_field, [79:16] payload, [86:80] payload_len, [87] zero
    output logic [xfde_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
    import xfde_pkg::*;

    logic         s1_valid_reg;
    logic [63:0]  s1_sample_reg;
    logic         out_valid_reg;
    xfde_result_t out_result_reg;
    xfde_result_t enc_result;
    logic         s1_move;
    logic         in_xfer;

    // input stage moves on when the result register is free or draining
    assign s1_move       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_move;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    xfde_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (s1_move),
        .sample (s1_sample_reg),
        .result (enc_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_sample_reg <= s_axis_tdata[63:0];
        end
        if (s1_move)
        begin
            out_result_reg <= enc_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_result_reg};

    `XFDE_ASSERT_NEXT(a_move_fills_out, clk, rst_n, s1_move, out_valid_reg)
    `XFDE_ASSERT_NEXT(a_xfer_fills_s1, clk, rst_n, in_xfer, s1_valid_reg)
    `XFDE_ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_valid_reg && !s1_move, s1_valid_reg && $stable(s1_sample_reg))

endmodule

`default_nettype wire
